// File: rtl/core/cpd_pkg.sv
// Package for the charger presence debounce block.
// Holds connect source codes, register indexes and reset values; no dependencies.
package cpd_pkg;

	localparam int CNT_W = 8;
	localparam int CFG_W = 8;
	localparam int IDX_W = 2;

	localparam logic [1:0] SRC_NONE  = 2'd0;
	localparam logic [1:0] SRC_USB   = 2'd1;
	localparam logic [1:0] SRC_STAND = 2'd2;

	localparam logic [IDX_W-1:0] REG_USB_CONFIRM   = 2'd0;
	localparam logic [IDX_W-1:0] REG_STAND_CONFIRM = 2'd1;
	localparam logic [IDX_W-1:0] REG_STAND_REMOVE  = 2'd2;
	localparam logic [IDX_W-1:0] REG_TEST_DISABLE  = 2'd3;

	localparam logic [CNT_W-1:0] USB_CONFIRM_RST   = 8'd2;
	localparam logic [CNT_W-1:0] STAND_CONFIRM_RST = 8'd2;
	localparam logic [CNT_W-1:0] STAND_REMOVE_RST  = 8'd40;
	localparam logic [CNT_W-1:0] CNT_MAX           = 8'd255;

endpackage

// File: rtl/core/charger_presence_debounce.sv
// Top level of the charger presence debounce block: input register, debounce
// and source select logic, result register. Depends on cpd_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one sample word per tick: the
//   USB and wireless stand detect levels. Output channel (out_valid /
//   out_stall) returns one result word per sample: debounced statuses,
//   connect source, reported source and event pulses.
//   Data path: a word accepted is registered in the input stage, passed
//   through the debounce update and registered in the result register,
//   which presents it on the output.
//   Throughput: one word per cycle while out_stall is low, set by the
//   debounce update of the channel counters between the two registers.
//   When the receiver stalls, the result register holds; the input stage
//   holds its word and in_stall rises once both are occupied.
//   Reset clears the statuses, counters and connect source, loads the
//   register defaults (confirm counts 2, removal count 40, test mode off)
//   and empties both stages. No result is produced by reset.
//   Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once
//   and are expected only while the block is idle.
module charger_presence_debounce (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [cpd_pkg::IDX_W-1:0]  cfg_index,
	input  logic [cpd_pkg::CFG_W-1:0]  cfg_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       usb_sense,
	input  logic                       stand_detect,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       usb_attached,
	output logic                       stand_present,
	output logic [1:0]                 connect_source,
	output logic [1:0]                 reported_source,
	output logic                       source_changed,
	output logic                       stop_charging,
	output logic                       wireless_start,
	output logic                       wireless_stop,
	output logic                       usb_path_off,
	output logic                       usb_busy,
	output logic                       stand_busy
);

	logic [cpd_pkg::CNT_W-1:0] usb_confirm_q, stand_confirm_q, stand_remove_q;
	logic                      test_disable_q;

	logic                      usb_status_q, stand_status_q;
	logic [cpd_pkg::CNT_W-1:0] usb_cnt_q, stand_cnt_q;
	logic [1:0]                source_q;

	logic valid_s1, usb_s1, stand_s1;
	logic advance;

	logic                      usb_mis, stand_mis, usb_flip, stand_flip, remove_sel;
	logic [cpd_pkg::CNT_W-1:0] usb_inc, stand_inc, stand_target;
	logic [cpd_pkg::CNT_W-1:0] usb_cnt_d, stand_cnt_d;
	logic                      usb_status_d, stand_status_d, changed;
	logic [1:0]                source_d;
	logic                      w_start_d, w_stop_d;

	logic                      out_valid_q;
	logic                      usb_attached_q, stand_present_q, changed_q, stop_q;
	logic [1:0]                source_out_q, reported_q;
	logic                      w_start_q, w_stop_q, path_off_q, usb_busy_q, stand_busy_q;

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			usb_confirm_q   <= cpd_pkg::USB_CONFIRM_RST;
			stand_confirm_q <= cpd_pkg::STAND_CONFIRM_RST;
			stand_remove_q  <= cpd_pkg::STAND_REMOVE_RST;
			test_disable_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				cpd_pkg::REG_USB_CONFIRM:   usb_confirm_q   <= cfg_data;
				cpd_pkg::REG_STAND_CONFIRM: stand_confirm_q <= cfg_data;
				cpd_pkg::REG_STAND_REMOVE:  stand_remove_q  <= cfg_data;
				cpd_pkg::REG_TEST_DISABLE:  test_disable_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			usb_s1   <= usb_sense;
			stand_s1 <= stand_detect;
		end
	end

	// debounce update
	always_comb begin
		usb_mis   = usb_s1 != usb_status_q;
		usb_inc   = (usb_cnt_q == cpd_pkg::CNT_MAX) ? usb_cnt_q
			: usb_cnt_q + cpd_pkg::CNT_W'(1);
		usb_flip  = usb_mis && (usb_inc >= usb_confirm_q);
		usb_cnt_d = (usb_mis && !usb_flip) ? usb_inc : '0;
		usb_status_d = usb_flip ? usb_s1 : usb_status_q;

		stand_mis    = stand_s1 != stand_status_q;
		stand_inc    = (stand_cnt_q == cpd_pkg::CNT_MAX) ? stand_cnt_q
			: stand_cnt_q + cpd_pkg::CNT_W'(1);
		remove_sel   = (source_q == cpd_pkg::SRC_STAND) && !stand_s1;
		stand_target = remove_sel ? stand_remove_q : stand_confirm_q;
		stand_flip   = stand_mis && (stand_inc >= stand_target);
		stand_cnt_d  = (stand_mis && !stand_flip) ? stand_inc : '0;
		stand_status_d = stand_flip ? stand_s1 : stand_status_q;

		changed = usb_flip || stand_flip;
		if (!changed)
			source_d = source_q;
		else if (usb_status_d)
			source_d = cpd_pkg::SRC_USB;
		else if (stand_status_d)
			source_d = cpd_pkg::SRC_STAND;
		else
			source_d = cpd_pkg::SRC_NONE;

		w_start_d = (!stand_mis && stand_s1 && (source_q == cpd_pkg::SRC_STAND))
			|| (changed && (source_d == cpd_pkg::SRC_STAND));
		w_stop_d  = (stand_mis && remove_sel)
			|| (changed && (source_d == cpd_pkg::SRC_USB));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			usb_status_q   <= 1'b0;
			stand_status_q <= 1'b0;
			usb_cnt_q      <= '0;
			stand_cnt_q    <= '0;
			source_q       <= cpd_pkg::SRC_NONE;
		end else if (advance) begin
			usb_status_q   <= usb_status_d;
			stand_status_q <= stand_status_d;
			usb_cnt_q      <= usb_cnt_d;
			stand_cnt_q    <= stand_cnt_d;
			source_q       <= source_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			usb_attached_q  <= usb_status_d;
			stand_present_q <= stand_status_d;
			source_out_q    <= source_d;
			reported_q      <= test_disable_q ? cpd_pkg::SRC_NONE : source_d;
			changed_q       <= changed;
			stop_q          <= changed && (source_d == cpd_pkg::SRC_NONE);
			w_start_q       <= w_start_d;
			w_stop_q        <= w_stop_d;
			path_off_q      <= usb_flip && !usb_s1;
			usb_busy_q      <= usb_cnt_d != '0;
			stand_busy_q    <= stand_cnt_d != '0;
		end
	end

	assign out_valid       = out_valid_q;
	assign usb_attached    = usb_attached_q;
	assign stand_present   = stand_present_q;
	assign connect_source  = source_out_q;
	assign reported_source = reported_q;
	assign source_changed  = changed_q;
	assign stop_charging   = stop_q;
	assign wireless_start  = w_start_q;
	assign wireless_stop   = w_stop_q;
	assign usb_path_off    = path_off_q;
	assign usb_busy        = usb_busy_q;
	assign stand_busy      = stand_busy_q;

	// source follows the statuses on every valid result, USB first
	a_source_priority: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> connect_source == (usb_attached ? cpd_pkg::SRC_USB :
			(stand_present ? cpd_pkg::SRC_STAND : cpd_pkg::SRC_NONE)))
		else $error("connect source disagrees with statuses");

	a_stop_none: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && stop_charging) |-> (source_changed && connect_source == cpd_pkg::SRC_NONE))
		else $error("stop charging without loss of source");

	a_path_off: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && usb_path_off) |-> (source_changed && !usb_attached))
		else $error("usb path off while usb still present");

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(source_q) && $stable(usb_cnt_q) && $stable(stand_cnt_q))
		else $error("debounce state moved without a word");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled with room in the pipeline");

endmodule
